// ===== hdl/csvt_pkg.sv =====
// Package: shared types, codes and defaults of the CSV quoted field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  // Default field buffer depth in bytes.
  localparam int MAX_FIELD_LEN = 32;

  // Field length counter width; holds the largest supported depth.
  localparam int FLEN_W = 6;

  // Configuration register width; values of 256 and above match no byte.
  localparam int CFG_W = 9;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DELIM_A = 3'd0;
  localparam logic [2:0] CFG_DELIM_B = 3'd1;
  localparam logic [2:0] CFG_QUOTE_A = 3'd2;
  localparam logic [2:0] CFG_QUOTE_B = 3'd3;
  localparam logic [2:0] CFG_ESCAPE  = 3'd4;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] RST_DELIM_A = 9'd44;
  localparam logic [CFG_W-1:0] RST_DELIM_B = 9'd256;
  localparam logic [CFG_W-1:0] RST_QUOTE_A = 9'd34;
  localparam logic [CFG_W-1:0] RST_QUOTE_B = 9'd256;
  localparam logic [CFG_W-1:0] RST_ESCAPE  = 9'd34;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_REC   = 2'd2;

  // Record status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISPLACED = 2'd1;
  localparam logic [1:0] ST_UNTERM    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] delim_a;
    logic [CFG_W-1:0] delim_b;
    logic [CFG_W-1:0] quote_a;
    logic [CFG_W-1:0] quote_b;
    logic [CFG_W-1:0] escape;
  } cfg_t;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_REC,        // record end only
    CMD_FIELD,      // drain the field buffer
    CMD_FIELD_REC   // drain the field buffer, then record end
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [1:0]        status;
    logic [FLEN_W-1:0] length;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_BYTES,
    B_EMPTY,
    B_REC
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/csvt_ifs.sv =====
// Interfaces: input byte channel and result channel.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       field_last;
  logic [1:0] record_status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output field_last,
                  output record_status, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input field_last,
                  input record_status, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/csvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module csvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/csvt_front.sv =====
// Front end: accepts bytes, runs the quote/escape state and writes the field buffer.
`timescale 1ns / 1ps
`default_nettype none

module csvt_front #(
  parameter int MAX_FIELD_LEN = csvt_pkg::MAX_FIELD_LEN,
  localparam int AW = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  csvt_in_if.sink             in_chan,
  input  wire logic           stall,
  input  wire csvt_pkg::cfg_t cfg,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                cmd_push,
  output csvt_pkg::cmd_t      cmd
);

  localparam logic [7:0] LF = 8'h0A;
  localparam logic [7:0] CR = 8'h0D;
  localparam logic [csvt_pkg::FLEN_W-1:0] LEN_MAX = csvt_pkg::FLEN_W'(MAX_FIELD_LEN);

  function automatic logic is_blank(input logic [7:0] b);
    return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20 || b == 8'h85 || b == 8'hA0;
  endfunction

  logic [csvt_pkg::FLEN_W-1:0] flen_r, flen_nxt;
  logic       inq_r, inq_nxt;
  logic [7:0] oq_r, oq_nxt;
  logic       esc_r, esc_nxt;
  logic       started_r, started_nxt;
  logic       qc_r, qc_nxt;
  logic       la_r, la_nxt;
  logic       skip_r, skip_nxt;

  logic       accept;
  logic [7:0] c;
  logic [csvt_pkg::CFG_W-1:0] cw;
  logic       store_req, fail_req;
  logic [1:0] fail_st;
  logic       inq_l, qc_l;
  logic       is_delim, is_qchar, is_quote, is_esc;

  assign in_chan.ready = !stall;
  assign accept        = in_chan.valid && !stall;
  assign c             = in_chan.text_byte;
  assign cw            = {1'b0, c};
  assign ram_waddr     = flen_r[AW-1:0];
  assign ram_wdata     = c;

  always_comb begin
    flen_nxt    = flen_r;
    inq_nxt     = inq_r;
    oq_nxt      = oq_r;
    esc_nxt     = esc_r;
    started_nxt = started_r;
    qc_nxt      = qc_r;
    la_nxt      = la_r;
    skip_nxt    = skip_r;
    cmd_push    = 1'b0;
    cmd         = '{kind: csvt_pkg::CMD_REC, status: csvt_pkg::ST_OK, length: '0};
    ram_we      = 1'b0;
    store_req   = 1'b0;
    fail_req    = 1'b0;
    fail_st     = csvt_pkg::ST_OK;
    inq_l       = inq_r;
    qc_l        = qc_r;
    is_delim    = 1'b0;
    is_qchar    = 1'b0;
    is_quote    = 1'b0;
    is_esc      = 1'b0;

    if (accept) begin
      if (skip_r) begin
        // dropping a failed record up to its end
        if (in_chan.op || c == LF || c == CR) begin
          skip_nxt = 1'b0;
        end
      end else if (in_chan.op) begin
        if (la_r) begin
          inq_l = 1'b0;
        end
        cmd_push = 1'b1;
        if (inq_l || esc_r) begin
          cmd.status = csvt_pkg::ST_UNTERM;
        end else if (started_r) begin
          cmd.kind   = csvt_pkg::CMD_FIELD_REC;
          cmd.length = flen_r;
        end
        flen_nxt    = '0;
        started_nxt = 1'b0;
        qc_nxt      = 1'b0;
        inq_nxt     = 1'b0;
        esc_nxt     = 1'b0;
        la_nxt      = 1'b0;
      end else if (esc_r) begin
        esc_nxt   = 1'b0;
        store_req = 1'b1;
      end else if (la_r && c == oq_r) begin
        // doubled quote: keep one
        la_nxt    = 1'b0;
        store_req = 1'b1;
      end else begin
        if (la_r) begin
          la_nxt = 1'b0;
          inq_l  = 1'b0;
          qc_l   = 1'b1;
        end
        inq_nxt  = inq_l;
        qc_nxt   = qc_l;
        is_delim = (cw == cfg.delim_a) || (cw == cfg.delim_b);
        if (!is_delim) begin
          is_qchar = (cw == cfg.quote_a) || (cw == cfg.quote_b);
          is_quote = inq_l ? (c == oq_r) : is_qchar;
          is_esc   = (cw == cfg.escape);
          if (is_qchar && is_esc) begin
            is_esc = is_quote;
          end
        end

        priority if (is_quote) begin
          if (inq_l) begin
            if (is_esc) begin
              la_nxt = 1'b1;
            end else begin
              inq_nxt = 1'b0;
              qc_nxt  = 1'b1;
            end
          end else if (!started_r) begin
            // opening quote drops leading blanks
            flen_nxt    = '0;
            oq_nxt      = c;
            inq_nxt     = 1'b1;
            started_nxt = 1'b1;
          end else begin
            fail_req = 1'b1;
            fail_st  = csvt_pkg::ST_MISPLACED;
          end
        end else if (is_esc) begin
          esc_nxt = 1'b1;
        end else if (inq_l) begin
          store_req = 1'b1;
        end else if (is_delim) begin
          cmd_push    = 1'b1;
          cmd.kind    = csvt_pkg::CMD_FIELD;
          cmd.length  = flen_r;
          flen_nxt    = '0;
          started_nxt = 1'b0;
          qc_nxt      = 1'b0;
        end else if (c == LF || c == CR) begin
          cmd_push = 1'b1;
          if (started_r) begin
            cmd.kind   = csvt_pkg::CMD_FIELD_REC;
            cmd.length = flen_r;
          end
          flen_nxt    = '0;
          started_nxt = 1'b0;
          qc_nxt      = 1'b0;
          inq_nxt     = 1'b0;
          esc_nxt     = 1'b0;
          la_nxt      = 1'b0;
        end else if (is_blank(c)) begin
          if (!qc_l) begin
            store_req = 1'b1;
          end
        end else if (qc_l) begin
          fail_req = 1'b1;
          fail_st  = csvt_pkg::ST_MISPLACED;
        end else begin
          store_req   = 1'b1;
          started_nxt = 1'b1;
        end
      end

      if (store_req) begin
        if (flen_r >= LEN_MAX) begin
          fail_req = 1'b1;
          fail_st  = csvt_pkg::ST_OVERFLOW;
        end else begin
          ram_we   = 1'b1;
          flen_nxt = flen_r + 1'b1;
        end
      end

      if (fail_req) begin
        cmd_push    = 1'b1;
        cmd         = '{kind: csvt_pkg::CMD_REC, status: fail_st, length: '0};
        flen_nxt    = '0;
        started_nxt = 1'b0;
        qc_nxt      = 1'b0;
        inq_nxt     = 1'b0;
        esc_nxt     = 1'b0;
        la_nxt      = 1'b0;
        skip_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r    <= '0;
      inq_r     <= 1'b0;
      oq_r      <= 8'h00;
      esc_r     <= 1'b0;
      started_r <= 1'b0;
      qc_r      <= 1'b0;
      la_r      <= 1'b0;
      skip_r    <= 1'b0;
    end else begin
      flen_r    <= flen_nxt;
      inq_r     <= inq_nxt;
      oq_r      <= oq_nxt;
      esc_r     <= esc_nxt;
      started_r <= started_nxt;
      qc_r      <= qc_nxt;
      la_r      <= la_nxt;
      skip_r    <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csvt_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module csvt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire csvt_pkg::cmd_t push_data,
  output logic                full,
  output logic                q_valid,
  input  wire logic           pop,
  output csvt_pkg::cmd_t      q_data
);

  csvt_pkg::cmd_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csvt_back.sv =====
// Back end: drains the field buffer and record ends into the result register.
`timescale 1ns / 1ps
`default_nettype none

module csvt_back #(
  parameter int MAX_FIELD_LEN = csvt_pkg::MAX_FIELD_LEN,
  localparam int AW = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire csvt_pkg::cmd_t q_data,
  output logic                pop,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  wire logic [7:0]     ram_rdata,
  output logic                field_done,
  csvt_out_if.source          out_chan
);

  csvt_pkg::back_state_t state_r, state_nxt;
  csvt_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [csvt_pkg::FLEN_W-1:0] iss_r, iss_nxt;
  logic [csvt_pkg::FLEN_W-1:0] cnt_r, cnt_nxt;
  logic       dv_r, dv_nxt;

  logic       ov_r, ov_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] data_r, data_nxt;
  logic       fl_r, fl_nxt;
  logic [1:0] st_r, st_nxt;
  logic       last_r, last_nxt;

  logic out_free, consume, byte_last, then_rec;

  assign out_free  = !ov_r || out_chan.ready;
  assign consume   = (state_r == csvt_pkg::B_BYTES) && dv_r && out_free;
  assign byte_last = (cnt_r + 1'b1) == cmd_r.length;
  assign then_rec  = (cmd_r.kind == csvt_pkg::CMD_FIELD_REC);
  assign ram_raddr = iss_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csvt_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_data.kind == csvt_pkg::CMD_REC) begin
            state_nxt = csvt_pkg::B_REC;
          end else if (q_data.length == '0) begin
            state_nxt = csvt_pkg::B_EMPTY;
          end else begin
            state_nxt = csvt_pkg::B_BYTES;
          end
        end
      end
      csvt_pkg::B_BYTES: begin
        if (consume && byte_last) begin
          state_nxt = then_rec ? csvt_pkg::B_REC : csvt_pkg::B_IDLE;
        end
      end
      csvt_pkg::B_EMPTY: begin
        if (out_free) begin
          state_nxt = then_rec ? csvt_pkg::B_REC : csvt_pkg::B_IDLE;
        end
      end
      csvt_pkg::B_REC: begin
        if (out_free) begin
          state_nxt = csvt_pkg::B_IDLE;
        end
      end
      default: state_nxt = csvt_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop        = 1'b0;
    ram_re     = 1'b0;
    field_done = 1'b0;
    cmd_nxt    = cmd_r;
    iss_nxt    = iss_r;
    cnt_nxt    = cnt_r;
    dv_nxt     = dv_r;
    ov_nxt     = ov_r && !out_chan.ready;
    kind_nxt   = kind_r;
    data_nxt   = data_r;
    fl_nxt     = fl_r;
    st_nxt     = st_r;
    last_nxt   = last_r;

    unique case (state_r)
      csvt_pkg::B_IDLE: begin
        pop = q_valid;
        if (q_valid) begin
          cmd_nxt = q_data;
          iss_nxt = '0;
          cnt_nxt = '0;
          dv_nxt  = 1'b0;
        end
      end
      csvt_pkg::B_BYTES: begin
        // keep one read in flight ahead of the result register
        ram_re = (iss_r < cmd_r.length) && (!dv_r || consume);
        if (ram_re) begin
          iss_nxt = iss_r + 1'b1;
          dv_nxt  = 1'b1;
        end else if (consume) begin
          dv_nxt = 1'b0;
        end
        if (consume) begin
          cnt_nxt    = cnt_r + 1'b1;
          ov_nxt     = 1'b1;
          kind_nxt   = csvt_pkg::KIND_BYTE;
          data_nxt   = ram_rdata;
          fl_nxt     = byte_last;
          st_nxt     = csvt_pkg::ST_OK;
          last_nxt   = byte_last && !then_rec;
          field_done = byte_last;
        end
      end
      csvt_pkg::B_EMPTY: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          kind_nxt   = csvt_pkg::KIND_EMPTY;
          data_nxt   = 8'h00;
          fl_nxt     = 1'b1;
          st_nxt     = csvt_pkg::ST_OK;
          last_nxt   = !then_rec;
          field_done = 1'b1;
        end
      end
      csvt_pkg::B_REC: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          kind_nxt = csvt_pkg::KIND_REC;
          data_nxt = 8'h00;
          fl_nxt   = 1'b0;
          st_nxt   = cmd_r.status;
          last_nxt = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    iss_r  <= iss_nxt;
    cnt_r  <= cnt_nxt;
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    fl_r   <= fl_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvt_pkg::B_IDLE;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_chan.valid         = ov_r;
  assign out_chan.kind          = kind_r;
  assign out_chan.data_byte     = data_r;
  assign out_chan.field_last    = fl_r;
  assign out_chan.record_status = st_r;
  assign out_chan.last          = last_r;

endmodule

`default_nettype wire

// ===== hdl/csv_quoted_field_tokenizer.sv =====
// Top level of the CSV quoted field tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// Splits a Latin-1 byte stream into CSV records and fields. Each input transfer
// carries one text byte (op = 0) or an end-of-buffer mark (op = 1) that closes
// the record. Fields end at either delimiter register; records end at an
// unquoted CR or LF or at an end mark. Two quote bytes and one escape byte are
// configurable; an escape byte that is also a quote escapes only itself inside
// quotes it opened (doubled quote). Results come out as one transfer per field
// byte, an empty-field transfer, or a record-end transfer with status; `last`
// marks the final result caused by an input transfer. An error reports the
// record end at once and drops input up to the next CR, LF or end mark.
// Rate: one input byte per cycle while no field is draining and the command
// queue is not full. A byte that ends a field (delimiter, CR/LF, end mark)
// holds input off until the back end has read the whole field out of the field
// buffer, one read per cycle while the result side accepts. Record-end and
// error results pass through the two-entry command queue, holding input only
// while it is full. The field buffer needs no clearing pass after reset.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods only.
module csv_quoted_field_tokenizer #(
  parameter int MAX_FIELD_LEN = csvt_pkg::MAX_FIELD_LEN,
  localparam int AW = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  csvt_in_if.sink                         in_chan,
  csvt_out_if.source                      out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [csvt_pkg::CFG_W-1:0] cfg_data
);

  // configuration registers
  csvt_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        csvt_pkg::CFG_DELIM_A: cfg_nxt.delim_a = cfg_data;
        csvt_pkg::CFG_DELIM_B: cfg_nxt.delim_b = cfg_data;
        csvt_pkg::CFG_QUOTE_A: cfg_nxt.quote_a = cfg_data;
        csvt_pkg::CFG_QUOTE_B: cfg_nxt.quote_b = cfg_data;
        csvt_pkg::CFG_ESCAPE:  cfg_nxt.escape  = cfg_data;
        default:               cfg_nxt = cfg_r;   // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_a <= csvt_pkg::RST_DELIM_A;
      cfg_r.delim_b <= csvt_pkg::RST_DELIM_B;
      cfg_r.quote_a <= csvt_pkg::RST_QUOTE_A;
      cfg_r.quote_b <= csvt_pkg::RST_QUOTE_B;
      cfg_r.escape  <= csvt_pkg::RST_ESCAPE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end <-> field buffer / queue
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic           cmd_push;
  csvt_pkg::cmd_t cmd;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  csvt_pkg::cmd_t q_data;
  logic           field_done;

  // A field handed to the back end owns the field buffer until fully read;
  // the front end holds off so it cannot overwrite bytes still to drain.
  logic fld_busy_r, fld_busy_nxt;
  logic front_stall;

  assign fld_busy_nxt = (cmd_push && cmd.kind != csvt_pkg::CMD_REC) ? 1'b1 :
                        field_done ? 1'b0 : fld_busy_r;
  assign front_stall  = q_full || fld_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_busy_r <= 1'b0;
    end else begin
      fld_busy_r <= fld_busy_nxt;
    end
  end

  csvt_front #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .stall    (front_stall),
    .cfg      (cfg_r),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // field buffer
  csvt_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FIELD_LEN)
  ) u_field_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  csvt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (q_pop),
    .q_data   (q_data)
  );

  csvt_back #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .field_done(field_done),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
